// File: sv/sem_pkg.sv
// shared types, constants and state encodings for the rgb sobel edge block
// no dependencies
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int NUM_LANES  = 3;
  localparam int PIX_W      = 8 * NUM_LANES;

  // above this sum of squares the rounded root is past the cap
  localparam logic [20:0] SAT_LIMIT = 21'd65280;
  localparam logic [7:0]  MAG_CAP   = 8'd255;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef logic [7:0] mag_t;

  typedef struct packed {
    logic last;
    logic eof;
  } out_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_LOAD,
    ST_ZSHIFT,
    ST_DRN_RD,
    ST_DRN_SHIFT,
    ST_CALC,
    ST_ROOT
  } sem_state_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_SQX,
    LN_SQY,
    LN_SAT,
    LN_ROOT,
    LN_ROUND
  } lane_state_t;

endpackage

// File: sv/sobel_edge_magnitude_rgb.sv
// rgb sobel edge magnitude: sequencer, 3x3 window, line stores, three lanes, output merge
// pixel item: in_stall stays high from transfer until the sequencer is back in idle; each result needs
// a pass of the per-lane iterative square root (8 root steps)
// drain item: line store reads and window shifts for three columns, then one root pass
// synchronous active-low reset clears counters and window; line stores are not cleared
// depends on sem_pkg, sem_line_store, sem_lane, sem_merge
module sobel_edge_magnitude_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_end_of_run,
  output logic        out_end_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import sem_pkg::*;

  sem_state_t state_r, state_nxt;

  logic [10:0]       width_r;
  logic [12:0]       height_r;
  logic [ADDR_W-1:0] col_r;
  logic [11:0]       row_r;
  logic [10:0]       drain_r;
  logic              in_drain_r;

  logic [ADDR_W-1:0] cur_c_r;
  logic [11:0]       cur_r_r;
  logic [PIX_W-1:0]  px_r;
  logic [1:0]        k_r;
  logic              ok_r;
  logic              last_r, eof_r, e2_r;
  logic [PIX_W-1:0]  win_r [9];

  logic [10:0]       w_eff;
  logic [12:0]       h_eff;
  logic [11:0]       x_full;
  logic              x_ok;
  logic              row_end, frame_end, e1, e2, drain_end;
  logic [ADDR_W-1:0] rd_addr;
  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]  col_top, col_mid, col_bot;
  logic              shift_en, clear_en, wr_en, lanes_start, lanes_done, merge_load;
  logic              merge_free;
  logic [NUM_LANES-1:0] lane_done;
  mag_t              lane_mag [NUM_LANES];
  out_flags_t        flags;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);

  assign w_eff = (width_r == 11'd0) ? 11'd1 :
                 (width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == 13'd0) ? 13'd1 :
                 (height_r > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_r;

  assign row_end   = (11'(cur_c_r) + 11'd1) >= w_eff;
  assign frame_end = (13'(cur_r_r) + 13'd1) >= h_eff;
  assign e1        = (cur_r_r != '0) && (cur_c_r != '0);
  assign e2        = (cur_r_r != '0) && row_end;
  assign drain_end = (12'(drain_r) + 12'd1) >= 12'(w_eff);

  // drain column read: drain count plus k minus one
  assign x_full = 12'(drain_r) + 12'(k_r) - 12'd1;
  assign x_ok   = ((k_r != 2'd0) || (drain_r != '0)) && (x_full < 12'(w_eff));

  assign lanes_done = &lane_done;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_PIXEL) state_nxt = ST_PIX_LOAD;
          else if (in_drain_r) state_nxt = ST_DRN_RD;
        end
      end
      ST_PIX_LOAD: begin
        if (e1) state_nxt = ST_CALC;
        else if (e2) state_nxt = ST_ZSHIFT;
        else state_nxt = ST_IDLE;
      end
      ST_ZSHIFT:    state_nxt = ST_CALC;
      ST_DRN_RD:    state_nxt = ST_DRN_SHIFT;
      ST_DRN_SHIFT: state_nxt = (k_r == 2'd2) ? ST_CALC : ST_DRN_RD;
      ST_CALC:      state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (lanes_done && merge_free) state_nxt = e2_r ? ST_ZSHIFT : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr     = in_drain_r ? '0 : col_r;
    col_top     = '0;
    col_mid     = '0;
    col_bot     = '0;
    shift_en    = 1'b0;
    clear_en    = 1'b0;
    wr_en       = 1'b0;
    lanes_start = 1'b0;
    merge_load  = 1'b0;
    case (state_r)
      ST_PIX_LOAD: begin
        col_top  = (cur_r_r >= 12'd2) ? rd_data[2*PIX_W-1:PIX_W] : '0;
        col_mid  = (cur_r_r != '0) ? rd_data[PIX_W-1:0] : '0;
        col_bot  = px_r;
        shift_en = 1'b1;
        clear_en = (cur_c_r == '0);
        wr_en    = 1'b1;
      end
      ST_ZSHIFT: shift_en = 1'b1;
      ST_DRN_RD: rd_addr = x_full[ADDR_W-1:0];
      ST_DRN_SHIFT: begin
        col_top  = ok_r ? rd_data[2*PIX_W-1:PIX_W] : '0;
        col_mid  = ok_r ? rd_data[PIX_W-1:0] : '0;
        shift_en = 1'b1;
      end
      ST_CALC: lanes_start = 1'b1;
      ST_ROOT: merge_load = lanes_done && merge_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      width_r    <= 11'(MAX_WIDTH);
      height_r   <= 13'd1;
      col_r      <= '0;
      row_r      <= '0;
      drain_r    <= '0;
      in_drain_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_data[10:0];
          CFG_HEIGHT: height_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == ST_IDLE && in_valid && in_command == CMD_PIXEL && in_drain_r) begin
        // a pixel abandons the drain and starts a new frame
        in_drain_r <= 1'b0;
        drain_r    <= '0;
      end
      if (state_r == ST_PIX_LOAD) begin
        if (row_end) begin
          col_r <= '0;
          if (frame_end) begin
            row_r      <= '0;
            in_drain_r <= 1'b1;
            drain_r    <= '0;
          end else begin
            row_r <= cur_r_r + 12'd1;
          end
        end else begin
          col_r <= cur_c_r + ADDR_W'(1);
        end
      end
      if (state_r == ST_DRN_SHIFT && k_r == 2'd2) begin
        if (drain_end) begin
          in_drain_r <= 1'b0;
          drain_r    <= '0;
        end else begin
          drain_r <= drain_r + 11'd1;
        end
      end
      if (shift_en) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= clear_en ? '0 : win_r[i*3+1];
          win_r[i*3+1] <= clear_en ? '0 : win_r[i*3+2];
        end
        win_r[2] <= col_top;
        win_r[5] <= col_mid;
        win_r[8] <= col_bot;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cur_c_r <= in_drain_r ? '0 : col_r;
        cur_r_r <= in_drain_r ? '0 : row_r;
        px_r    <= {in_red, in_green, in_blue};
        k_r     <= 2'd0;
      end
      ST_PIX_LOAD: begin
        last_r <= e1 ? !row_end : 1'b1;
        eof_r  <= 1'b0;
        e2_r   <= e1 && e2;
      end
      ST_ZSHIFT: begin
        last_r <= 1'b1;
        e2_r   <= 1'b0;
      end
      ST_DRN_RD: ok_r <= x_ok;
      ST_DRN_SHIFT: begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd2) begin
          last_r <= 1'b1;
          eof_r  <= drain_end;
          e2_r   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  sem_line_store u_lines (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_c_r),
    .wr_data ({col_mid, px_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mag_t lane_px [9];
    for (genvar j = 0; j < 9; j++) begin : g_tap
      assign lane_px[j] = win_r[j][PIX_W-1-8*g -: 8];
    end
    sem_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lanes_start),
      .px    (lane_px),
      .done  (lane_done[g]),
      .mag   (lane_mag[g])
    );
  end

  assign flags.last = last_r;
  assign flags.eof  = eof_r;

  sem_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (merge_load),
    .mag              (lane_mag),
    .flags            (flags),
    .out_stall        (out_stall),
    .free             (merge_free),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// File: sv/sem_line_store.sv
// two line stores packed side by side: older row in the upper half, newer in the lower
// depends on sem_pkg
module sem_line_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [sem_pkg::ADDR_W-1:0]     wr_addr,
  input  logic [2*sem_pkg::PIX_W-1:0]    wr_data,
  input  logic [sem_pkg::ADDR_W-1:0]     rd_addr,
  output logic [2*sem_pkg::PIX_W-1:0]    rd_data
);
  import sem_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/sem_lane.sv
// one colour lane: sobel gradients, sum of squares and iterative rounded square root
// depends on sem_pkg
module sem_lane (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  sem_pkg::mag_t px [9],
  output logic          done,
  output sem_pkg::mag_t mag
);
  import sem_pkg::*;

  lane_state_t st_r, st_nxt;
  logic [9:0]  ax_r, ay_r;
  logic [20:0] n_r;
  logic [7:0]  res_r;
  logic [2:0]  bit_r;
  logic        done_r;

  logic [9:0]  xp, xn, yp, yn;
  logic [9:0]  mul_a, mul_b;
  logic [19:0] prod;
  logic [7:0]  cand;

  assign xp = 10'(px[2]) + {1'b0, px[5], 1'b0} + 10'(px[8]);
  assign xn = 10'(px[0]) + {1'b0, px[3], 1'b0} + 10'(px[6]);
  assign yp = 10'(px[6]) + {1'b0, px[7], 1'b0} + 10'(px[8]);
  assign yn = 10'(px[0]) + {1'b0, px[1], 1'b0} + 10'(px[2]);

  assign cand = res_r | (8'd1 << bit_r);
  assign prod = mul_a * mul_b;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      LN_IDLE:  if (start) st_nxt = LN_SQX;
      LN_SQX:   st_nxt = LN_SQY;
      LN_SQY:   st_nxt = LN_SAT;
      LN_SAT:   st_nxt = (n_r > SAT_LIMIT) ? LN_IDLE : LN_ROOT;
      LN_ROOT:  if (bit_r == 3'd0) st_nxt = LN_ROUND;
      LN_ROUND: st_nxt = LN_IDLE;
      default:  st_nxt = LN_IDLE;
    endcase
  end

  // one shared multiplier per lane
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      LN_SQX: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
      LN_SQY: begin
        mul_a = ay_r;
        mul_b = ay_r;
      end
      LN_ROOT: begin
        mul_a = 10'(cand);
        mul_b = 10'(cand);
      end
      LN_ROUND: begin
        mul_a = 10'(res_r);
        mul_b = 10'(res_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= LN_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == LN_IDLE && start) done_r <= 1'b0;
      if (st_r == LN_SAT && n_r > SAT_LIMIT) done_r <= 1'b1;
      if (st_r == LN_ROUND) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      LN_IDLE: begin
        if (start) begin
          ax_r <= (xp >= xn) ? xp - xn : xn - xp;
          ay_r <= (yp >= yn) ? yp - yn : yn - yp;
        end
      end
      LN_SQX: n_r <= 21'(prod);
      LN_SQY: n_r <= n_r + 21'(prod);
      LN_SAT: begin
        if (n_r > SAT_LIMIT) begin
          res_r <= MAG_CAP;
        end else begin
          res_r <= '0;
          bit_r <= 3'd7;
        end
      end
      LN_ROOT: begin
        if (21'(prod) <= n_r) res_r <= cand;
        bit_r <= bit_r - 3'd1;
      end
      LN_ROUND: begin
        // round half up: n above r*r + r
        if (n_r > 21'(prod) + 21'(res_r)) res_r <= res_r + 8'd1;
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign mag  = res_r;

endmodule

// File: sv/sem_merge.sv
// merging stage: gathers the three lane magnitudes and flags into the output register
// depends on sem_pkg
module sem_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sem_pkg::mag_t       mag [sem_pkg::NUM_LANES],
  input  sem_pkg::out_flags_t flags,
  input  logic                out_stall,
  output logic                free,
  output logic                out_valid,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                out_end_of_run,
  output logic                out_end_of_frame
);
  import sem_pkg::*;

  logic       valid_r, valid_nxt;
  mag_t       mag_r [NUM_LANES];
  out_flags_t flags_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r   <= mag;
      flags_r <= flags;
    end
  end

  assign out_valid        = valid_r;
  assign out_red          = mag_r[0];
  assign out_green        = mag_r[1];
  assign out_blue         = mag_r[2];
  assign out_end_of_run   = flags_r.last;
  assign out_end_of_frame = flags_r.eof;

endmodule

// File: sv/sem_check.sv
// port-level checks for the rgb sobel edge block, bound to the top level
// depends on sobel_edge_magnitude_rgb ports only
module sem_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_end_of_run,
  input logic        out_end_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(out_end_of_run) && $stable(out_end_of_frame))
    else $error("stalled result changed");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_end_of_frame || out_end_of_run))
    else $error("frame end without end of run");

  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_command |=> in_stall)
    else $error("pixel transfer not followed by a busy cycle");

endmodule

bind sobel_edge_magnitude_rgb sem_check u_sem_check (.*);
